// ===== hdl/bfm_pkg.sv =====
package bfm_pkg;

   localparam int PIXEL_W = 8;
   localparam int PIXEL_MAX = 255;
   localparam int CFG_W = 11;
   localparam int COORD_W = 10;
   localparam int RSP_DATA_W = 32;
   localparam int CSR_INDEX_W = 2;
   localparam int K_W = 3;

   localparam int DEF_MAX_WIDTH = 1024;
   localparam int DEF_MAX_HEIGHT = 1024;
   localparam int DEF_MAX_MASK = 7;
   localparam int SMALL_K = 3;

   localparam int RECIP_SHIFT = 20;
   localparam int RECIP_W = 17;

   localparam logic [CFG_W-1:0] RESET_WIDTH = 11'd1024;
   localparam logic [CFG_W-1:0] RESET_HEIGHT = 11'd1024;

   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MASK_SELECT = 2'd2;

   localparam logic MASK_LARGE = 1'b1;

   typedef struct packed {
      logic emit;
      logic eof;
   } bfm_tag_type;

   // Scaled reciprocal of k*k; exact truncation for every window sum of 8-bit pixels.
   function automatic logic [RECIP_W-1:0] recip_for(input logic [K_W-1:0] k);
      logic [RECIP_W-1:0] m;
      case (k)
         3'd3: m = 17'd116509;
         3'd4: m = 17'd65536;
         3'd5: m = 17'd41944;
         3'd6: m = 17'd29128;
         3'd7: m = 17'd21400;
         default: m = '0;
      endcase
      return m;
   endfunction

endpackage

// ===== hdl/bfm_ram.sv =====
module bfm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              enable,
   input  logic              write_enable,
   input  logic [ADDR_W-1:0] address,
   input  logic [WIDTH-1:0]  write_data,
   output logic [WIDTH-1:0]  read_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // The read returns the contents from before a write to the same address.
   always_ff @(posedge clock) begin
      if (enable) begin
         if (write_enable) begin
            mem_ff[address] <= write_data;
         end
         rdata_ff <= mem_ff[address];
      end
   end

   assign read_data = rdata_ff;

endmodule

// ===== hdl/bfm_locate.sv =====
module bfm_locate import bfm_pkg::*; #(
   parameter int MAX_WIDTH = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
   parameter int MAX_MASK = DEF_MAX_MASK,
   localparam int COL_W = $clog2(MAX_WIDTH),
   localparam int ROW_W = $clog2(MAX_HEIGHT),
   localparam int SLOTS = MAX_MASK - 1,
   localparam int SLOT_W = $clog2(SLOTS)
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  logic               start_of_frame,
   input  logic [CFG_W-1:0]   image_width,
   input  logic [CFG_W-1:0]   image_height,
   input  logic               mask_select,
   output logic [COL_W-1:0]   col,
   output logic [SLOT_W-1:0]  slot,
   output logic [COORD_W-1:0] centre_row,
   output logic [COORD_W-1:0] centre_col,
   output bfm_tag_type        tag
);

   localparam int WW = COL_W + 1;
   localparam int HW = ROW_W + 1;
   localparam int WCMP = (WW > CFG_W) ? WW : CFG_W;
   localparam int HCMP = (HW > CFG_W) ? HW : CFG_W;
   localparam int RXW = (HW > COORD_W) ? HW : COORD_W;
   localparam int CXW = (WW > COORD_W) ? WW : COORD_W;

   logic [COL_W-1:0]  col_ff;
   logic [ROW_W-1:0]  row_ff;
   logic [SLOT_W-1:0] slot_ff;

   logic [WCMP-1:0]   w_cmp;
   logic [HCMP-1:0]   h_cmp;
   logic [WW-1:0]     w_eff;
   logic [HW-1:0]     h_eff;
   logic [K_W-1:0]    k_m1;
   logic [K_W-1:0]    half;
   logic [WW-1:0]     c;
   logic [HW-1:0]     r;
   logic [SLOT_W-1:0] s;
   logic [WW-1:0]     c_in;
   logic [HW-1:0]     r_in;
   logic [SLOT_W-1:0] s_in;
   logic [RXW-1:0]    row_diff;
   logic [CXW-1:0]    col_diff;

   function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] v);
      logic [SLOT_W-1:0] n;
      n = (v == SLOT_W'(SLOTS - 1)) ? '0 : v + SLOT_W'(1);
      return n;
   endfunction

   always_comb begin
      w_cmp = WCMP'(image_width);
      if (w_cmp == '0) begin
         w_cmp = WCMP'(1);
      end else if (w_cmp > WCMP'(MAX_WIDTH)) begin
         w_cmp = WCMP'(MAX_WIDTH);
      end
      h_cmp = HCMP'(image_height);
      if (h_cmp == '0) begin
         h_cmp = HCMP'(1);
      end else if (h_cmp > HCMP'(MAX_HEIGHT)) begin
         h_cmp = HCMP'(MAX_HEIGHT);
      end
      w_eff = w_cmp[WW-1:0];
      h_eff = h_cmp[HW-1:0];

      k_m1 = (mask_select == MASK_LARGE) ? K_W'(MAX_MASK - 1) : K_W'(SMALL_K - 1);
      half = k_m1 >> 1;

      // A stored position that lies outside a smaller frame moves on to the next row or row 0.
      if (start_of_frame) begin
         c = '0;
         r = '0;
         s = '0;
      end else begin
         c = WW'(col_ff);
         r = HW'(row_ff);
         s = slot_ff;
         if (c >= w_eff) begin
            c = '0;
            r = r + HW'(1);
            s = slot_inc(s);
         end
         if (r >= h_eff) begin
            r = '0;
            s = '0;
         end
      end

      tag.emit = (r >= HW'(k_m1)) && (c >= WW'(k_m1));
      tag.eof = (r == h_eff - HW'(1)) && (c == w_eff - WW'(1));
      row_diff = RXW'(r) - RXW'(half);
      col_diff = CXW'(c) - CXW'(half);

      c_in = c + WW'(1);
      r_in = r;
      s_in = s;
      if (c_in >= w_eff) begin
         c_in = '0;
         r_in = r + HW'(1);
         s_in = slot_inc(s);
         if (r_in >= h_eff) begin
            r_in = '0;
            s_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
         slot_ff <= '0;
      end else if (accept) begin
         col_ff <= c_in[COL_W-1:0];
         row_ff <= r_in[ROW_W-1:0];
         slot_ff <= s_in;
      end
   end

   assign col = c[COL_W-1:0];
   assign slot = s;
   assign centre_row = row_diff[COORD_W-1:0];
   assign centre_col = col_diff[COORD_W-1:0];

endmodule

// ===== hdl/bfm_window.sv =====
module bfm_window import bfm_pkg::*; #(
   parameter int MAX_MASK = DEF_MAX_MASK,
   localparam int SLOTS = MAX_MASK - 1,
   localparam int SLOT_W = $clog2(SLOTS),
   localparam int SUM_W = $clog2(PIXEL_MAX * MAX_MASK * MAX_MASK + 1)
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           load,
   input  logic                           mask_select,
   input  logic [PIXEL_W-1:0]             pixel,
   input  logic [SLOT_W-1:0]              slot,
   input  logic [SLOTS-1:0][PIXEL_W-1:0]  line_data,
   output logic [SUM_W-1:0]               window_sum
);

   localparam int IDX_W = $clog2(2 * SLOTS);
   localparam int SMALL_COL_W = $clog2(PIXEL_MAX * SMALL_K + 1);
   localparam int LARGE_COL_W = $clog2(PIXEL_MAX * MAX_MASK + 1);

   logic [PIXEL_W-1:0]     column [MAX_MASK];
   logic [IDX_W-1:0]       idx;
   logic [SMALL_COL_W-1:0] small_col;
   logic [LARGE_COL_W-1:0] large_col;
   logic [SMALL_COL_W-1:0] small_ff [SMALL_K];
   logic [LARGE_COL_W-1:0] large_ff [MAX_MASK];
   logic [SUM_W-1:0]       small_sum;
   logic [SUM_W-1:0]       large_sum;

   // Row i back of the new column sits in the line slot i rows behind the current one.
   always_comb begin
      column[0] = pixel;
      for (int i = 1; i < MAX_MASK; i++) begin
         idx = IDX_W'(slot) + IDX_W'(SLOTS - i);
         if (idx >= IDX_W'(SLOTS)) begin
            idx = idx - IDX_W'(SLOTS);
         end
         column[i] = line_data[idx[SLOT_W-1:0]];
      end
      small_col = '0;
      for (int i = 0; i < SMALL_K; i++) begin
         small_col = small_col + SMALL_COL_W'(column[i]);
      end
      large_col = '0;
      for (int i = 0; i < MAX_MASK; i++) begin
         large_col = large_col + LARGE_COL_W'(column[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < SMALL_K; j++) begin
            small_ff[j] <= '0;
         end
         for (int j = 0; j < MAX_MASK; j++) begin
            large_ff[j] <= '0;
         end
      end else if (load) begin
         small_ff[0] <= small_col;
         for (int j = 1; j < SMALL_K; j++) begin
            small_ff[j] <= small_ff[j-1];
         end
         large_ff[0] <= large_col;
         for (int j = 1; j < MAX_MASK; j++) begin
            large_ff[j] <= large_ff[j-1];
         end
      end
   end

   always_comb begin
      small_sum = '0;
      for (int j = 0; j < SMALL_K; j++) begin
         small_sum = small_sum + SUM_W'(small_ff[j]);
      end
      large_sum = '0;
      for (int j = 0; j < MAX_MASK; j++) begin
         large_sum = large_sum + SUM_W'(large_ff[j]);
      end
   end

   assign window_sum = (mask_select == MASK_LARGE) ? large_sum : small_sum;

endmodule

// ===== hdl/bfm_mean.sv =====
module bfm_mean import bfm_pkg::*; #(
   parameter int MAX_MASK = DEF_MAX_MASK,
   localparam int SUM_W = $clog2(PIXEL_MAX * MAX_MASK * MAX_MASK + 1)
) (
   input  logic [SUM_W-1:0]   window_sum,
   input  logic               mask_select,
   output logic [PIXEL_W-1:0] mean_value
);

   localparam int PROD_W = SUM_W + RECIP_W;

   logic [K_W-1:0]    k;
   logic [PROD_W-1:0] product;

   assign k = (mask_select == MASK_LARGE) ? K_W'(MAX_MASK) : K_W'(SMALL_K);
   assign product = PROD_W'(window_sum) * PROD_W'(recip_for(k));
   assign mean_value = product[RECIP_SHIFT +: PIXEL_W];

endmodule

// ===== hdl/box_filter_mean_core.sv =====
// Box filter mean core: takes one 8-bit pixel word per clock in raster order and returns the
// truncated mean of the 3x3 or 7x7 window that the pixel completes, tagged with the window
// centre; border pixels give no result, and tlast marks the result whose window ends on the
// last pixel of the frame. A pixel flows through a four-register pipeline (line store read,
// column sums, window sum, reciprocal multiply), so one word is taken every cycle unless the
// pipeline stalls; req_tready drops only when every stage is full behind a result that
// rsp_tready does not take. The previous rows live in one RAM per row slot, which need no
// clearing after reset. Write the registers only while the core is idle.
module box_filter_mean_core import bfm_pkg::*; #(
   parameter int MAX_WIDTH = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
   parameter int MAX_MASK = DEF_MAX_MASK
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [PIXEL_W-1:0]     req_tdata,   // pixel
   input  logic                   req_tuser,   // start_of_frame
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_DATA_W-1:0]  rsp_tdata,   // mean_value, centre_row, centre_col, zero fill
   output logic                   rsp_tlast,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]       csr_wdata
);

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int SLOTS = MAX_MASK - 1;
   localparam int SLOT_W = $clog2(SLOTS);
   localparam int SUM_W = $clog2(PIXEL_MAX * MAX_MASK * MAX_MASK + 1);
   localparam int PAD_W = RSP_DATA_W - PIXEL_W - 2 * COORD_W;

   logic [CFG_W-1:0] image_width_ff;
   logic [CFG_W-1:0] image_height_ff;
   logic             mask_select_ff;

   logic accept;
   logic out_free, s3_go, s3_free, s2_go, s2_free, s1_go, s1_free;
   logic v1_ff, v2_ff, v3_ff, rsp_valid_ff;
   logic v1_in, v2_in, v3_in, rsp_valid_in;

   logic [COL_W-1:0]   loc_col;
   logic [SLOT_W-1:0]  loc_slot;
   logic [COORD_W-1:0] loc_row_c, loc_col_c;
   bfm_tag_type        loc_tag;

   logic [SLOTS-1:0][PIXEL_W-1:0] line_data;

   logic [PIXEL_W-1:0] px1_ff;
   logic [SLOT_W-1:0]  slot1_ff;
   logic [COORD_W-1:0] crow1_ff, ccol1_ff, crow2_ff, ccol2_ff, crow3_ff, ccol3_ff;
   logic [COORD_W-1:0] crow_ff, ccol_ff;
   bfm_tag_type        tag1_ff, tag2_ff, tag3_ff;
   logic [SUM_W-1:0]   window_sum;
   logic [SUM_W-1:0]   sum3_ff;
   logic [PIXEL_W-1:0] mean_value;
   logic [PIXEL_W-1:0] mean_ff;
   logic               eof_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff <= RESET_WIDTH;
         image_height_ff <= RESET_HEIGHT;
         mask_select_ff <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH: image_width_ff <= csr_wdata;
            CSR_IMAGE_HEIGHT: image_height_ff <= csr_wdata;
            CSR_MASK_SELECT: mask_select_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Words that complete no window leave the last stage without touching the output register.
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign s3_go = v3_ff && (!tag3_ff.emit || out_free);
   assign s3_free = !v3_ff || s3_go;
   assign s2_go = v2_ff && s3_free;
   assign s2_free = !v2_ff || s2_go;
   assign s1_go = v1_ff && s2_free;
   assign s1_free = !v1_ff || s1_go;
   assign req_tready = s1_free;
   assign accept = req_tvalid && req_tready;

   assign v1_in = accept ? 1'b1 : (s1_go ? 1'b0 : v1_ff);
   assign v2_in = s1_go ? 1'b1 : (s2_go ? 1'b0 : v2_ff);
   assign v3_in = s2_go ? 1'b1 : (s3_go ? 1'b0 : v3_ff);
   assign rsp_valid_in = (s3_go && tag3_ff.emit) ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   bfm_locate #(
      .MAX_WIDTH(MAX_WIDTH),
      .MAX_HEIGHT(MAX_HEIGHT),
      .MAX_MASK(MAX_MASK)
   ) u_locate (
      .clock(clock),
      .reset(reset),
      .accept(accept),
      .start_of_frame(req_tuser),
      .image_width(image_width_ff),
      .image_height(image_height_ff),
      .mask_select(mask_select_ff),
      .col(loc_col),
      .slot(loc_slot),
      .centre_row(loc_row_c),
      .centre_col(loc_col_c),
      .tag(loc_tag)
   );

   for (genvar g = 0; g < SLOTS; g++) begin : g_line
      bfm_ram #(
         .WIDTH(PIXEL_W),
         .DEPTH(MAX_WIDTH)
      ) u_ram (
         .clock(clock),
         .enable(accept),
         .write_enable(loc_slot == SLOT_W'(g)),
         .address(loc_col),
         .write_data(req_tdata),
         .read_data(line_data[g])
      );
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         px1_ff <= req_tdata;
         slot1_ff <= loc_slot;
         crow1_ff <= loc_row_c;
         ccol1_ff <= loc_col_c;
         tag1_ff <= loc_tag;
      end
      if (s1_go) begin
         crow2_ff <= crow1_ff;
         ccol2_ff <= ccol1_ff;
         tag2_ff <= tag1_ff;
      end
      if (s2_go) begin
         sum3_ff <= window_sum;
         crow3_ff <= crow2_ff;
         ccol3_ff <= ccol2_ff;
         tag3_ff <= tag2_ff;
      end
      if (s3_go && tag3_ff.emit) begin
         mean_ff <= mean_value;
         crow_ff <= crow3_ff;
         ccol_ff <= ccol3_ff;
         eof_ff <= tag3_ff.eof;
      end
   end

   bfm_window #(
      .MAX_MASK(MAX_MASK)
   ) u_window (
      .clock(clock),
      .reset(reset),
      .load(s1_go),
      .mask_select(mask_select_ff),
      .pixel(px1_ff),
      .slot(slot1_ff),
      .line_data(line_data),
      .window_sum(window_sum)
   );

   bfm_mean #(
      .MAX_MASK(MAX_MASK)
   ) u_mean (
      .window_sum(sum3_ff),
      .mask_select(mask_select_ff),
      .mean_value(mean_value)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {PAD_W'(0), ccol_ff, crow_ff, mean_ff};
   assign rsp_tlast = eof_ff;

endmodule

// ===== hdl/bfm_checker.sv =====
module bfm_checker import bfm_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic                  rsp_tlast
);

   // A result word that is not taken stays in place with its contents.
   rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result word changed while stalled");

   // After reset the pipeline is empty: nothing to deliver and room for a new word.
   reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("pipeline not empty after reset");

   // The input side only backs up when a result word is stuck at the output.
   ready_backpressure: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("input stalled without output back-pressure");

   // An accepted word never blocks the next one unless the output is stuck.
   accept_follow: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !(rsp_tvalid && !rsp_tready) |=> req_tready || rsp_tvalid)
      else $error("input stalled right after an accepted word");

endmodule

bind box_filter_mean_core bfm_checker u_checker (
   .clock(clock),
   .reset(reset),
   .req_tvalid(req_tvalid),
   .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata(rsp_tdata),
   .rsp_tlast(rsp_tlast)
);

// ===== tb/sv/box_filter_mean_checker.sv =====
module box_filter_mean_checker import bfm_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic [PIXEL_W-1:0]     req_tdata,   // pixel
   input  logic                   req_tuser,   // start_of_frame
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic [RSP_DATA_W-1:0]  rsp_tdata,   // mean_value, centre_row, centre_col, zero fill
   input  logic                   rsp_tlast,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]       csr_wdata,
   output int                     failures,
   output int                     pending
);

   localparam int ROW_SLOTS = DEF_MAX_MASK - 1;
   localparam int ROW_LSB = PIXEL_W;
   localparam int COL_LSB = PIXEL_W + COORD_W;
   localparam int FILL_LSB = PIXEL_W + 2 * COORD_W;

   typedef struct packed {
      logic [PIXEL_W-1:0] mean;
      logic [COORD_W-1:0] row;
      logic [COORD_W-1:0] col;
      logic               eof;
   } window_mean_type;

   window_mean_type    expected_means[$];
   logic [PIXEL_W-1:0] row_store [0:ROW_SLOTS*DEF_MAX_WIDTH-1];
   logic [PIXEL_W-1:0] window [0:DEF_MAX_MASK-1][0:DEF_MAX_MASK-1];
   logic [CFG_W-1:0]   width_reg = RESET_WIDTH;
   logic [CFG_W-1:0]   height_reg = RESET_HEIGHT;
   logic               mask_reg = 1'b0;
   int                 next_col = 0;
   int                 next_row = 0;
   int                 miss_count = 0;

   function automatic int clamp_dim(input logic [CFG_W-1:0] v, input int hi);
      if (v == '0) return 1;
      if (int'(v) > hi) return hi;
      return int'(v);
   endfunction

   task automatic flag_mismatch(input string field, input int want, input int got);
      miss_count++;
      $error("%s expected %0d actual %0d", field, want, got);
   endtask

   task automatic slide_window(input logic [PIXEL_W-1:0] px, input logic sof);
      int              w, h, k, r, c, rs, slot, half;
      integer          sum;
      window_mean_type res;
      w = clamp_dim(width_reg, DEF_MAX_WIDTH);
      h = clamp_dim(height_reg, DEF_MAX_HEIGHT);
      k = (mask_reg == MASK_LARGE) ? DEF_MAX_MASK : SMALL_K;
      if (sof) begin
         r = 0;
         c = 0;
      end else begin
         r = next_row;
         c = next_col;
         if (c >= w) begin
            c = 0;
            r = r + 1;
         end
         if (r >= h) r = 0;
      end
      for (int i = 0; i < DEF_MAX_MASK; i++) begin
         for (int j = DEF_MAX_MASK - 1; j > 0; j--) window[i][j] = window[i][j-1];
      end
      rs = r % ROW_SLOTS;
      window[0][0] = px;
      for (int i = 1; i < DEF_MAX_MASK; i++) begin
         slot = (rs + ROW_SLOTS - i) % ROW_SLOTS;
         window[i][0] = row_store[slot * DEF_MAX_WIDTH + c];
      end
      row_store[rs * DEF_MAX_WIDTH + c] = px;
      if (r + 1 >= k && c + 1 >= k) begin
         sum = 0;
         half = (k - 1) / 2;
         for (int i = 0; i < k; i++) begin
            for (int j = 0; j < k; j++) sum = sum + window[i][j];
         end
         res.mean = PIXEL_W'(sum / (k * k));
         res.row = COORD_W'(r - half);
         res.col = COORD_W'(c - half);
         res.eof = (r == h - 1) && (c == w - 1);
         expected_means.push_back(res);
      end
      c = c + 1;
      if (c >= w) begin
         c = 0;
         r = r + 1;
         if (r >= h) r = 0;
      end
      next_col = c;
      next_row = r;
   endtask

   task automatic check_word();
      window_mean_type want;
      if (expected_means.size() == 0) begin
         miss_count++;
         $error("result word with no expected mean waiting: tdata %h tlast %b",
                rsp_tdata, rsp_tlast);
      end else begin
         want = expected_means.pop_front();
         if (rsp_tdata[PIXEL_W-1:0] !== want.mean)
            flag_mismatch("mean_value", want.mean, rsp_tdata[PIXEL_W-1:0]);
         if (rsp_tdata[ROW_LSB +: COORD_W] !== want.row)
            flag_mismatch("centre_row", want.row, rsp_tdata[ROW_LSB +: COORD_W]);
         if (rsp_tdata[COL_LSB +: COORD_W] !== want.col)
            flag_mismatch("centre_col", want.col, rsp_tdata[COL_LSB +: COORD_W]);
         if (rsp_tlast !== want.eof)
            flag_mismatch("end_of_frame", want.eof, rsp_tlast);
         if (rsp_tdata[RSP_DATA_W-1:FILL_LSB] !== '0)
            flag_mismatch("tdata zero fill", 0, rsp_tdata[RSP_DATA_W-1:FILL_LSB]);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         width_reg = RESET_WIDTH;
         height_reg = RESET_HEIGHT;
         mask_reg = 1'b0;
         for (int i = 0; i < DEF_MAX_MASK; i++) begin
            for (int j = 0; j < DEF_MAX_MASK; j++) window[i][j] = '0;
         end
         next_col = 0;
         next_row = 0;
         expected_means.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_IMAGE_WIDTH: width_reg = csr_wdata;
               CSR_IMAGE_HEIGHT: height_reg = csr_wdata;
               CSR_MASK_SELECT: mask_reg = csr_wdata[0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) slide_window(req_tdata, req_tuser);
         if (rsp_tvalid && rsp_tready) check_word();
      end
      failures <= miss_count;
      pending <= expected_means.size();
   end

endmodule

// ===== tb/sv/tb.sv =====
module tb;
   import bfm_pkg::*;

   typedef enum int {
      PIX_UNIFORM,
      PIX_EXTREME,
      PIX_WHITE,
      PIX_BLACK,
      PIX_DARK
   } pixel_mode_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [PIXEL_W-1:0]     req_tdata = '0;   // pixel
   logic                   req_tuser = 1'b0; // start_of_frame
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;        // mean_value, centre_row, centre_col, zero fill
   logic                   rsp_tlast;
   logic                   csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CFG_W-1:0]       csr_wdata = '0;

   int                     failures;
   int                     pending;
   logic                   calm = 1'b0;
   logic [CFG_W-1:0]       cur_width = RESET_WIDTH;
   logic [CFG_W-1:0]       cur_height = RESET_HEIGHT;
   logic                   cur_mask = 1'b0;

   box_filter_mean_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   box_filter_mean_checker u_mean_check (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .failures   (failures),
      .pending    (pending)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      #(20 * 1000000);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   always @(posedge clock) begin
      rsp_tready <= calm || ($urandom_range(99) >= 29);
   end

   function automatic int eff_size(input logic [CFG_W-1:0] v, input int hi);
      if (v == '0) return 1;
      if (int'(v) > hi) return hi;
      return int'(v);
   endfunction

   function automatic logic [PIXEL_W-1:0] pick_pixel(input pixel_mode_type mode);
      case (mode)
         PIX_EXTREME: return $urandom_range(1) ? PIXEL_W'(PIXEL_MAX) : '0;
         PIX_WHITE: return PIXEL_W'(PIXEL_MAX);
         PIX_BLACK: return '0;
         PIX_DARK: return PIXEL_W'($urandom_range(7));
         default: return PIXEL_W'($urandom_range(PIXEL_MAX));
      endcase
   endfunction

   task automatic offer_pixel(input logic [PIXEL_W-1:0] px, input logic sof);
      if (!calm) begin
         while ($urandom_range(99) < 29) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tdata <= px;
      req_tuser <= sof;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic send_run(input int count, input pixel_mode_type mode, input logic lead_sof,
                           input int frame_len, input int noise_pct);
      logic sof;
      for (int i = 0; i < count; i++) begin
         if (i == 0) sof = lead_sof;
         else if (i % frame_len == 0) sof = $urandom_range(99) < 70;
         else sof = $urandom_range(99) < noise_pct;
         offer_pixel(pick_pixel(mode), sof);
      end
   endtask

   // The core must be drained before any register changes: wait for the last
   // expected word, then let the pipeline empty out behind pixels with no result.
   task automatic load_geometry(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
                                input logic m, input logic [2:0] sel);
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (sel[0]) begin
         csr_we <= 1'b1;
         csr_index <= CSR_IMAGE_WIDTH;
         csr_wdata <= w;
         @(posedge clock);
         cur_width = w;
      end
      if (sel[1]) begin
         csr_we <= 1'b1;
         csr_index <= CSR_IMAGE_HEIGHT;
         csr_wdata <= h;
         @(posedge clock);
         cur_height = h;
      end
      if (sel[2]) begin
         csr_we <= 1'b1;
         csr_index <= CSR_MASK_SELECT;
         csr_wdata <= CFG_W'(m);
         @(posedge clock);
         cur_mask = m;
      end
      csr_we <= 1'b0;
   endtask

   initial begin
      int               random_items;
      int               phase;
      int               pick;
      int               fw;
      int               fh;
      int               old_eff;
      int               frame_len;
      int               count;
      logic             lead;
      logic [CFG_W-1:0] nw;
      logic [CFG_W-1:0] nh;
      logic             nm;
      logic [2:0]       sel;
      pixel_mode_type   mode;

      random_items = 0;
      phase = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      send_run(4, PIX_EXTREME, 1'b1, DEF_MAX_WIDTH * DEF_MAX_HEIGHT, 0);

      load_geometry(CFG_W'(3), CFG_W'(3), 1'b0, 3'b111);
      send_run(9, PIX_WHITE, 1'b1, 9, 0);
      send_run(9, PIX_BLACK, 1'b0, 9, 0);

      // A frame smaller than the window yields nothing.
      load_geometry('0, '0, 1'b0, 3'b011);
      send_run(3, PIX_UNIFORM, 1'b1, 1, 50);

      load_geometry(CFG_W'(7), CFG_W'(7), MASK_LARGE, 3'b111);
      send_run(49, PIX_UNIFORM, 1'b1, 49, 0);
      send_run(49, PIX_WHITE, 1'b0, 49, 0);

      load_geometry(CFG_W'(2047), CFG_W'(3), 1'b0, 3'b111);
      send_run(120, PIX_UNIFORM, 1'b1, 120, 0);

      load_geometry(CFG_W'(3), CFG_W'(2047), 1'b0, 3'b011);
      send_run(120, PIX_UNIFORM, 1'b1, 120, 0);

      while (random_items < 1300) begin
         calm = (phase >= 4) && (phase < 9);
         pick = $urandom_range(99);
         if (pick < 70) nw = CFG_W'($urandom_range(3, 16));
         else if (pick < 88) nw = CFG_W'($urandom_range(17, 48));
         else if (pick < 94) nw = CFG_W'($urandom_range(0, 7));
         else if (pick < 97) nw = CFG_W'($urandom_range(49, 200));
         else nw = CFG_W'($urandom_range(201, 2047));
         pick = $urandom_range(99);
         if (pick < 75) nh = CFG_W'($urandom_range(1, 12));
         else if (pick < 92) nh = CFG_W'($urandom_range(13, 40));
         else if (pick < 96) nh = CFG_W'($urandom_range(0, 2));
         else nh = CFG_W'($urandom_range(1025, 2047));
         nm = $urandom_range(1);
         sel[0] = $urandom_range(99) < 70;
         sel[1] = $urandom_range(99) < 70;
         sel[2] = $urandom_range(99) < 70;
         old_eff = eff_size(cur_width, DEF_MAX_WIDTH);
         load_geometry(nw, nh, nm, sel);

         // A wider row in mid-frame would read line store columns never written,
         // so any widening starts a fresh frame.
         fw = eff_size(cur_width, DEF_MAX_WIDTH);
         fh = eff_size(cur_height, DEF_MAX_HEIGHT);
         frame_len = fw * fh;
         count = frame_len * $urandom_range(1, 2);
         if (count > 400) count = 400;
         if ($urandom_range(99) < 30) count += $urandom_range(1, 2 * fw);
         lead = (fw > old_eff) || ($urandom_range(99) < 60);
         pick = $urandom_range(99);
         if (pick < 60) mode = PIX_UNIFORM;
         else if (pick < 75) mode = PIX_EXTREME;
         else if (pick < 85) mode = PIX_WHITE;
         else if (pick < 92) mode = PIX_BLACK;
         else mode = PIX_DARK;
         send_run(count, mode, lead, frame_len, 1);
         random_items += count;
         phase++;
      end
      calm = 1'b0;

      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (12) @(posedge clock);
      if (failures == 0 && pending == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
